### rtl/m4vt_pkg.sv
// shared constants and types for the 4x4 matrix vector transform
// no dependencies
package m4vt_pkg;

  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_W    = $clog2(NUM_REGS);
  localparam int CFG_IDX_W    = 8;
  localparam int REG_W        = 64;
  localparam int COEF_W       = 32;
  localparam int LANES        = 4;
  localparam int DEF_FRAC_BITS = 16;
  localparam int PROD_W       = 2 * COEF_W;
  localparam int PAIR_W       = PROD_W + 1;
  localparam int SUM_W        = PROD_W + 2;

  localparam logic [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [REG_W-1:0] cfg_reg_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

### rtl/m4vt_if.sv
// handshake channels: input vectors, result vectors and register writes
// depends on m4vt_pkg
interface m4vt_in_if;
  import m4vt_pkg::*;
  logic  valid;
  logic  ready;
  coef_t in_x;
  coef_t in_y;
  coef_t in_z;
  coef_t in_w;
  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface m4vt_out_if;
  import m4vt_pkg::*;
  logic  valid;
  logic  ready;
  coef_t out_x;
  coef_t out_y;
  coef_t out_z;
  coef_t out_w;
  logic  clipped;
  modport source (output valid, out_x, out_y, out_z, out_w, clipped, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, clipped, output ready);
endinterface

interface m4vt_cfg_if;
  import m4vt_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_reg_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/m4vt_lane.sv
// one output lane: four products, two adder levels, shift and saturate
// depends on m4vt_pkg; stage enables come from the top level
module m4vt_lane #(
  parameter int FRAC_BITS = m4vt_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  m4vt_pkg::stage_en_t en,
  input  m4vt_pkg::coef_t     coef [m4vt_pkg::LANES],
  input  m4vt_pkg::coef_t     vec  [m4vt_pkg::LANES],
  output m4vt_pkg::coef_t     result,
  output logic                sat
);
  import m4vt_pkg::*;

  localparam int HI_LSB = COEF_W - 1 + FRAC_BITS;

  logic signed [PROD_W-1:0] prod [LANES];
  logic signed [PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]  sum;
  logic                     ovf_pos;
  logic                     ovf_neg;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < LANES; c++) begin
        prod[c] <= $signed(coef[c]) * $signed(vec[c]);
      end
    end
    if (en.s2) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
    if (en.s3) begin
      sum <= SUM_W'(pair[0]) + SUM_W'(pair[1]);
    end
    if (en.s4) begin
      if (ovf_pos) begin
        result <= SAT_MAX;
      end else if (ovf_neg) begin
        result <= SAT_MIN;
      end else begin
        result <= sum[HI_LSB:FRAC_BITS];
      end
      sat <= ovf_pos | ovf_neg;
    end
  end

  // bits above the kept window must all match the sign
  always_comb begin
    ovf_pos = !sum[SUM_W-1] && (|sum[SUM_W-1:HI_LSB]);
    ovf_neg = sum[SUM_W-1] && !(&sum[SUM_W-1:HI_LSB]);
  end

endmodule

### rtl/matrix4_vector_transform_top.sv
// 4x4 matrix times vector, Q16.16 fixed point, four-stage pipeline
// depends on m4vt_pkg, m4vt_if, m4vt_lane
//
// Channels: vertex takes one vector (in_x..in_w) per item, result gives
// one vector (out_x..out_w) plus clipped per item, cfg writes one 64-bit
// coefficient register (index 0..7, two coefficients each, lower column
// in bits 31..0); writes to other indexes are dropped. cfg is always ready
// and must only be used while no item is in flight.
// Order: an accepted item moves through the multiply, pair add, final add and
// shift and saturate registers in turn; result valid rises once it is in the last.
// Throughput: one item per cycle while result is taken; stages are multiply,
// pair add, final add, shift and saturate, each holding one item.
// Reset: pipeline empties and the matrix returns to the identity.
// Stall: when result is not taken, each stage holds its item and empty
// stages behind it keep filling; vertex ready drops only once all four
// stages hold items.
module matrix4_vector_transform_top #(
  parameter int FRAC_BITS = m4vt_pkg::DEF_FRAC_BITS
) (
  input logic         clk,
  input logic         rst,
  m4vt_in_if.sink     vertex,
  m4vt_out_if.source  result,
  m4vt_cfg_if.sink    cfg
);
  import m4vt_pkg::*;

  localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] ONE_HI = ONE_LO << COEF_W;

  cfg_reg_t  coef_regs [NUM_REGS];
  logic [3:0] valid_q;
  stage_en_t en;
  coef_t     vec [LANES];
  coef_t     row_coef [LANES][LANES];
  coef_t     lane_res [LANES];
  logic [LANES-1:0] lane_sat;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_regs[0] <= ONE_LO;
      coef_regs[1] <= '0;
      coef_regs[2] <= ONE_HI;
      coef_regs[3] <= '0;
      coef_regs[4] <= '0;
      coef_regs[5] <= ONE_LO;
      coef_regs[6] <= '0;
      coef_regs[7] <= ONE_HI;
    end else if (cfg.valid && cfg.ready && (cfg.index < CFG_IDX_W'(NUM_REGS))) begin
      coef_regs[cfg.index[REG_IDX_W-1:0]] <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;

  // stage enables: a stage moves when empty or when the one ahead moves
  always_comb begin
    en.s4 = !valid_q[3] || result.ready;
    en.s3 = !valid_q[2] || en.s4;
    en.s2 = !valid_q[1] || en.s3;
    en.s1 = !valid_q[0] || en.s2;
  end

  assign vertex.ready = en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (en.s1) valid_q[0] <= vertex.valid;
      if (en.s2) valid_q[1] <= valid_q[0];
      if (en.s3) valid_q[2] <= valid_q[1];
      if (en.s4) valid_q[3] <= valid_q[2];
    end
  end

  always_comb begin
    vec[0] = vertex.in_x;
    vec[1] = vertex.in_y;
    vec[2] = vertex.in_z;
    vec[3] = vertex.in_w;
    for (int r = 0; r < LANES; r++) begin
      row_coef[r][0] = coef_regs[2*r][COEF_W-1:0];
      row_coef[r][1] = coef_regs[2*r][REG_W-1:COEF_W];
      row_coef[r][2] = coef_regs[2*r+1][COEF_W-1:0];
      row_coef[r][3] = coef_regs[2*r+1][REG_W-1:COEF_W];
    end
  end

  for (genvar r = 0; r < LANES; r++) begin : g_lane
    m4vt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (en),
      .coef   (row_coef[r]),
      .vec    (vec),
      .result (lane_res[r]),
      .sat    (lane_sat[r])
    );
  end

  assign result.valid   = valid_q[3];
  assign result.out_x   = lane_res[0];
  assign result.out_y   = lane_res[1];
  assign result.out_z   = lane_res[2];
  assign result.out_w   = lane_res[3];
  assign result.clipped = |lane_sat;

  // item count in the pipeline follows accepts and deliveries
  a_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(valid_q) == $past($countones(valid_q))
              + int'($past(vertex.valid && vertex.ready))
              - int'($past(result.valid && result.ready))))
    else $error("pipeline item count mismatch");

  // no acceptance while full and stalled
  a_full: assert property (@(posedge clk) disable iff (rst)
    ((&valid_q) && !result.ready) |-> !vertex.ready)
    else $error("accepted into a full stalled pipeline");

  // clipped only with a saturated lane value
  a_clip: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.clipped) |->
      (result.out_x == SAT_MAX || result.out_x == SAT_MIN ||
       result.out_y == SAT_MAX || result.out_y == SAT_MIN ||
       result.out_z == SAT_MAX || result.out_z == SAT_MIN ||
       result.out_w == SAT_MAX || result.out_w == SAT_MIN))
    else $error("clipped set without a saturated lane");

endmodule
